// ----- src/fccm_pkg.sv -----
// ----------------------------------------------------------------------------
// fccm_pkg
// Types and codes shared by the cluster chain manager and its checker.
// ----------------------------------------------------------------------------
package fccm_pkg;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_NEXT   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DIR_FULL  = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_BAD_ARG   = 3'd4;

  localparam logic [8:0] LINK_FREE = 9'd510;
  localparam logic [8:0] LINK_END  = 9'd511;

  typedef struct packed {
    logic [2:0] opcode;
    logic [8:0] file_name;
    logic [8:0] cluster_count;
    logic [8:0] cluster_index;
    logic [6:0] byte_offset;
    logic [7:0] write_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] cluster_out;
    logic [7:0] read_byte;
    logic       chain_end;
  } out_t;

  typedef struct packed {
    logic [8:0] name;
    logic [8:0] first;
  } dir_ent_t;

endpackage

// ----- src/fccm_ram.sv -----
// ----------------------------------------------------------------------------
// fccm_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fccm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/fat_cluster_chain_manager.sv -----
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager
// FAT-style store: directory, cluster link table and cluster data store.
//
//   Channel  Signals                            Beat
//   in       in_valid_i, in_ready_o, in_data_i  one command
//   out      out_valid_o, out_ready_i, out_data_o one result per command
//
// One shared counter scans the memories one entry at a time, because each
// read goes through a registered memory port.
// After reset a clearing pass zeroes the directory and data store and marks
// every link free before the first command is taken.
// A waiting result stalls only the end of the next command.
// ----------------------------------------------------------------------------
module fat_cluster_chain_manager #(
  parameter int CLUSTERS      = 256,
  parameter int DIR_ENTRIES   = 256,
  parameter int CLUSTER_BYTES = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fccm_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fccm_pkg::out_t  out_data_o
);

  localparam int DATA_DEPTH = CLUSTERS * CLUSTER_BYTES;
  localparam int DIR_AW     = DIR_ENTRIES > 1 ? $clog2(DIR_ENTRIES) : 1;
  localparam int CL_AW      = CLUSTERS > 1 ? $clog2(CLUSTERS) : 1;
  localparam int DAT_AW     = DATA_DEPTH > 1 ? $clog2(DATA_DEPTH) : 1;
  localparam int SCAN_N     = DIR_ENTRIES > CLUSTERS ? DIR_ENTRIES : CLUSTERS;
  localparam int IW         = $clog2(SCAN_N + 1);
  localparam int CLR_N      = DIR_ENTRIES > DATA_DEPTH ? DIR_ENTRIES : DATA_DEPTH;
  localparam int CLRW       = $clog2(CLR_N + 1);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DIR_RD   = 4'd2;
  localparam logic [3:0] S_DIR_CK   = 4'd3;
  localparam logic [3:0] S_FREE_RD  = 4'd4;
  localparam logic [3:0] S_FREE_CK  = 4'd5;
  localparam logic [3:0] S_CHAIN_RD = 4'd6;
  localparam logic [3:0] S_CHAIN_CK = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;
  localparam logic [3:0] S_NEXT_RD  = 4'd9;
  localparam logic [3:0] S_NEXT_CK  = 4'd10;
  localparam logic [3:0] S_DATA     = 4'd11;
  localparam logic [3:0] S_DATA_CK  = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [CLRW-1:0]   clr_q, clr_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [8:0]        found_q, found_d;
  logic [DIR_AW-1:0] slot_q, slot_d;
  logic [CL_AW-1:0]  prev_q, prev_d;
  logic [CL_AW-1:0]  first_q, first_d;
  logic [DAT_AW-1:0] daddr_q, daddr_d;
  fccm_pkg::in_t     cmd_q, cmd_d;
  fccm_pkg::out_t    res_q, res_d;
  fccm_pkg::out_t    out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              dir_we, link_we, data_we;
  logic [DIR_AW-1:0] dir_waddr;
  logic [CL_AW-1:0]  link_waddr;
  logic [DAT_AW-1:0] data_waddr;
  fccm_pkg::dir_ent_t dir_wdata, dir_rdata;
  logic [8:0]        link_wdata, link_rdata, link_raddr_full;
  logic [7:0]        data_wdata, data_rdata;
  logic [CL_AW-1:0]  link_raddr;
  logic [8:0]        dir_target;
  logic              cl_ok, off_ok, last_hit;

  assign cl_ok    = {1'b0, in_data_i.cluster_index} < 10'(CLUSTERS);
  assign off_ok   = {4'b0, in_data_i.byte_offset} < 11'(CLUSTER_BYTES);
  assign last_hit = ({1'b0, found_q} + 10'd1) == {1'b0, cmd_q.cluster_count};
  assign dir_target = (cmd_q.opcode == fccm_pkg::OP_CREATE) ? 9'd0 : cmd_q.file_name;
  assign link_raddr_full = (state_q == S_NEXT_RD) ? cmd_q.cluster_index : 9'(idx_q);
  assign link_raddr = link_raddr_full[CL_AW-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    found_d     = found_q;
    slot_d      = slot_q;
    prev_d      = prev_q;
    first_d     = first_q;
    daddr_d     = daddr_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    dir_we      = 1'b0;
    dir_waddr   = slot_q;
    dir_wdata   = '{name: cmd_q.file_name, first: 9'(first_q)};
    link_we     = 1'b0;
    link_waddr  = prev_q;
    link_wdata  = 9'(idx_q);
    data_we     = 1'b0;
    data_waddr  = daddr_q;
    data_wdata  = cmd_q.write_byte;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        dir_we     = clr_q < CLRW'(DIR_ENTRIES);
        dir_waddr  = clr_q[DIR_AW-1:0];
        dir_wdata  = '0;
        link_we    = clr_q < CLRW'(CLUSTERS);
        link_waddr = clr_q[CL_AW-1:0];
        link_wdata = fccm_pkg::LINK_FREE;
        data_we    = clr_q < CLRW'(DATA_DEPTH);
        data_waddr = clr_q[DAT_AW-1:0];
        data_wdata = '0;
        clr_d      = clr_q + CLRW'(1);
        if (clr_q == CLRW'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = in_data_i;
          idx_d   = '0;
          found_d = '0;
          daddr_d = DAT_AW'(int'(in_data_i.cluster_index) * CLUSTER_BYTES
                    + int'(in_data_i.byte_offset));
          res_d   = '{status: fccm_pkg::ST_BAD_ARG, default: '0};
          state_d = S_DONE;
          unique case (in_data_i.opcode) inside
            fccm_pkg::OP_CREATE: begin
              if (in_data_i.file_name != 9'd0 && in_data_i.cluster_count != 9'd0) begin
                state_d = S_DIR_RD;
              end
            end
            fccm_pkg::OP_LOOKUP: begin
              if (in_data_i.file_name != 9'd0) begin
                state_d = S_DIR_RD;
              end
            end
            fccm_pkg::OP_NEXT: begin
              if (cl_ok) begin
                state_d = S_NEXT_RD;
              end
            end
            fccm_pkg::OP_WRITE, fccm_pkg::OP_READ: begin
              if (cl_ok && off_ok) begin
                state_d = S_DATA;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIR_RD: begin
        if (idx_q == IW'(DIR_ENTRIES)) begin
          res_d.status = (cmd_q.opcode == fccm_pkg::OP_CREATE) ?
                         fccm_pkg::ST_DIR_FULL : fccm_pkg::ST_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          state_d = S_DIR_CK;
        end
      end
      S_DIR_CK: begin
        if (dir_rdata.name == dir_target) begin
          if (cmd_q.opcode == fccm_pkg::OP_CREATE) begin
            slot_d  = idx_q[DIR_AW-1:0];
            idx_d   = '0;
            state_d = S_FREE_RD;
          end else begin
            res_d.status      = fccm_pkg::ST_OK;
            res_d.cluster_out = dir_rdata.first;
            state_d           = S_DONE;
          end
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_DIR_RD;
        end
      end
      S_FREE_RD: begin
        if (idx_q == IW'(CLUSTERS)) begin
          res_d.status = fccm_pkg::ST_NO_SPACE;
          state_d      = S_DONE;
        end else begin
          state_d = S_FREE_CK;
        end
      end
      S_FREE_CK: begin
        idx_d   = idx_q + IW'(1);
        state_d = S_FREE_RD;
        if (link_rdata == fccm_pkg::LINK_FREE) begin
          found_d = found_q + 9'd1;
          if (last_hit) begin
            idx_d   = '0;
            found_d = '0;
            state_d = S_CHAIN_RD;
          end
        end
      end
      S_CHAIN_RD: begin
        state_d = S_CHAIN_CK;
      end
      S_CHAIN_CK: begin
        idx_d   = idx_q + IW'(1);
        state_d = S_CHAIN_RD;
        if (link_rdata == fccm_pkg::LINK_FREE) begin
          if (found_q == 9'd0) begin
            first_d = idx_q[CL_AW-1:0];
          end else begin
            link_we = 1'b1;
          end
          prev_d  = idx_q[CL_AW-1:0];
          found_d = found_q + 9'd1;
          if (last_hit) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        link_we           = 1'b1;
        link_wdata        = fccm_pkg::LINK_END;
        dir_we            = 1'b1;
        res_d.status      = fccm_pkg::ST_OK;
        res_d.cluster_out = 9'(first_q);
        state_d           = S_DONE;
      end
      S_NEXT_RD: begin
        state_d = S_NEXT_CK;
      end
      S_NEXT_CK: begin
        res_d.status      = fccm_pkg::ST_OK;
        res_d.cluster_out = link_rdata;
        res_d.chain_end   = link_rdata == fccm_pkg::LINK_END;
        state_d           = S_DONE;
      end
      S_DATA: begin
        if (cmd_q.opcode == fccm_pkg::OP_WRITE) begin
          data_we      = 1'b1;
          res_d.status = fccm_pkg::ST_OK;
          state_d      = S_DONE;
        end else begin
          state_d = S_DATA_CK;
        end
      end
      S_DATA_CK: begin
        res_d.status    = fccm_pkg::ST_OK;
        res_d.read_byte = data_rdata;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    found_q <= found_d;
    slot_q  <= slot_d;
    prev_q  <= prev_d;
    first_q <= first_d;
    daddr_q <= daddr_d;
    cmd_q   <= cmd_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  fccm_ram #(.WIDTH(18), .DEPTH(DIR_ENTRIES)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (idx_q[DIR_AW-1:0]),
    .rdata_o (dir_rdata)
  );

  fccm_ram #(.WIDTH(9), .DEPTH(CLUSTERS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  fccm_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (daddr_q),
    .rdata_o (data_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/fccm_checker.sv -----
// ----------------------------------------------------------------------------
// fccm_checker
// Port-level checks of the cluster chain manager, bound to its top level.
// ----------------------------------------------------------------------------
module fccm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input fccm_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result beat dropped or changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Command taken while a command is still in work.");

  a_chain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.chain_end |->
      out_data_o.status == fccm_pkg::ST_OK && out_data_o.cluster_out == fccm_pkg::LINK_END)
    else $error("Chain end flagged without an end link.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != fccm_pkg::ST_OK |->
      out_data_o.cluster_out == 9'd0 && out_data_o.read_byte == 8'd0 && !out_data_o.chain_end)
    else $error("Failed command returned nonzero data.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= fccm_pkg::ST_BAD_ARG)
    else $error("Status code out of range.");

endmodule

bind fat_cluster_chain_manager fccm_checker u_fccm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
